// File: rtl/core/humidity_temp_frame_decoder_unit_assert.svh
// Assertion macros shared by the frame decoder RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define HTFD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htfd assertion failed");

// next-cycle implication
`define HTFD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htfd assertion failed");

// invariant
`define HTFD_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("htfd assertion failed");

`endif

// File: rtl/core/htfd_pkg.sv
// Shared types, constants and the CRC-8 step function for the frame decoder.
// No dependencies.
package htfd_pkg;

  localparam logic [7:0]  CRC_INIT         = 8'hFF;
  localparam logic [7:0]  CRC_POLY         = 8'h31;
  localparam int          BUSY_BIT         = 7;
  localparam logic [2:0]  FRAME_DATA_BYTES = 3'd6;
  localparam logic [19:0] TEMP_RAW_LIMIT   = 20'd786432;
  localparam logic [13:0] HUM_SCALE        = 14'd10000;
  localparam logic [14:0] TEMP_SCALE       = 15'd20000;
  localparam logic [15:0] TEMP_OFFSET      = 16'd5000;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BUSY  = 2'd1,
    STATUS_CRC   = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [19:0] hum_raw;
    logic [19:0] temp_raw;
  } frame_rec_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/humidity_temp_frame_decoder_unit.sv
// The seventh byte loads the frame register, which then feeds the output result register.
// Throughput: one byte per cycle; the frame register and result register form a
// two-entry pipeline, so input stalls only when both are full and the output stalls.
// Reset (synchronous, active high) clears the byte index, sets the CRC to 0xFF,
// clears the frame store and drops any pending result.
// Depends on htfd_pkg, htfd_frame, htfd_scale and the assertion macro header.
`include "humidity_temp_frame_decoder_unit_assert.svh"

module humidity_temp_frame_decoder_unit import htfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status_code,
  output logic [19:0]        humidity_counts,
  output logic [19:0]        temperature_counts,
  output logic [13:0]        humidity_centi,
  output logic signed [14:0] temperature_centi
);

  logic       accept;
  logic       done;
  logic       advance;
  logic       s1_valid;
  frame_rec_t rec;
  frame_rec_t s1_rec;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  htfd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .done        (done),
    .rec         (rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && done) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      s1_rec <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  htfd_scale u_scale (
    .clk                (clk),
    .load               (advance && s1_valid),
    .rec                (s1_rec),
    .status_code        (status_code),
    .humidity_counts    (humidity_counts),
    .temperature_counts (temperature_counts),
    .humidity_centi     (humidity_centi),
    .temperature_centi  (temperature_centi)
  );

  `HTFD_ASSERT_NXT(a_done_fills_stage, clk, rst, accept && done, s1_valid)
  `HTFD_ASSERT_IMP(a_out_from_stage, clk, rst, $rose(out_valid), $past(s1_valid))
  `HTFD_ASSERT_IMP(a_stall_when_full, clk, rst, in_stall, s1_valid && out_valid && out_stall)

endmodule

// File: rtl/core/htfd_frame.sv
// Byte framing: CRC-8 accumulation, frame byte store and raw field unpacking.
// Depends on htfd_pkg and the assertion macro header.
`include "humidity_temp_frame_decoder_unit_assert.svh"

module htfd_frame import htfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       done,
  output frame_rec_t rec
);

  logic [2:0]  byte_index;
  logic [7:0]  crc;
  logic [47:0] frame_store;

  logic [2:0]  eff_index;
  logic [7:0]  eff_crc;
  logic [47:0] eff_store;
  logic [7:0]  b0, b1, b2, b3, b4, b5;

  always_comb begin
    eff_index = frame_start ? 3'd0 : byte_index;
    eff_crc   = frame_start ? CRC_INIT : crc;
    eff_store = frame_start ? 48'd0 : frame_store;
    done      = (eff_index >= FRAME_DATA_BYTES);
    b0 = eff_store[47:40];
    b1 = eff_store[39:32];
    b2 = eff_store[31:24];
    b3 = eff_store[23:16];
    b4 = eff_store[15:8];
    b5 = eff_store[7:0];
    rec.hum_raw  = {b1, b2, b3[7:4]};
    rec.temp_raw = {b3[3:0], b4, b5};
    if (b0[BUSY_BIT]) begin
      rec.status = STATUS_BUSY;
    end else if (eff_crc != rx_byte) begin
      rec.status = STATUS_CRC;
    end else if (rec.temp_raw > TEMP_RAW_LIMIT) begin
      rec.status = STATUS_RANGE;
    end else begin
      rec.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= 3'd0;
      crc         <= CRC_INIT;
      frame_store <= 48'd0;
    end else if (accept) begin
      if (done) begin
        byte_index  <= 3'd0;
        crc         <= CRC_INIT;
        frame_store <= 48'd0;
      end else begin
        byte_index  <= eff_index + 3'd1;
        crc         <= crc8_update(eff_crc, rx_byte);
        frame_store <= {eff_store[39:0], rx_byte};
      end
    end
  end

  `HTFD_ASSERT_ALWAYS(a_index_range, clk, rst, byte_index <= FRAME_DATA_BYTES)
  `HTFD_ASSERT_NXT(a_start_restarts, clk, rst, accept && frame_start, byte_index == 3'd1)
  `HTFD_ASSERT_NXT(a_done_clears, clk, rst, accept && done,
                   byte_index == 3'd0 && crc == CRC_INIT && frame_store == 48'd0)

endmodule

// File: rtl/core/htfd_scale.sv
// Fixed-point scaling of the raw values into the result register.
// Depends on htfd_pkg.
module htfd_scale import htfd_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  frame_rec_t         rec,
  output logic [1:0]         status_code,
  output logic [19:0]        humidity_counts,
  output logic [19:0]        temperature_counts,
  output logic [13:0]        humidity_centi,
  output logic signed [14:0] temperature_centi
);

  logic [33:0] hum_prod;
  logic [34:0] temp_prod;
  logic [15:0] temp_diff;

  always_comb begin
    hum_prod  = 34'(rec.hum_raw) * 34'(HUM_SCALE);
    temp_prod = 35'(rec.temp_raw) * 35'(TEMP_SCALE);
    temp_diff = {1'b0, temp_prod[34:20]} - TEMP_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_code        <= rec.status;
      humidity_counts    <= rec.hum_raw;
      temperature_counts <= rec.temp_raw;
      humidity_centi     <= hum_prod[33:20];
      temperature_centi  <= signed'(temp_diff[14:0]);
    end
  end

endmodule

// File: tb/sv/humidity_temp_frame_decoder_checker.sv
// Checker for the humidity and temperature frame decoder: watches both channels,
// decodes accepted bytes on its own and compares every result transfer.
// Depends on htfd_pkg for the status codes and the CRC and limit constants.
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_checker import htfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        status_code,
  input  logic [19:0]       humidity_counts,
  input  logic [19:0]       temperature_counts,
  input  logic [13:0]       humidity_centi,
  input  logic signed [14:0] temperature_centi,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    status_t            status;
    logic [19:0]        hum_raw;
    logic [19:0]        temp_raw;
    logic [13:0]        hum_centi;
    logic signed [14:0] temp_centi;
  } reading_t;

  reading_t    reading_q[$];
  logic [2:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [47:0] frame_bytes;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [7:0] crc8_shift_in(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    repeat (8) begin
      if (c[7]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  always @(posedge clk) begin : watch
    reading_t    want;
    reading_t    got;
    logic [63:0] prod;
    int          temp_c;
    if (rst) begin
      frame_pos   = 3'd0;
      crc_acc     = CRC_INIT;
      frame_bytes = 48'd0;
      reading_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (frame_start) begin
          frame_pos   = 3'd0;
          crc_acc     = CRC_INIT;
          frame_bytes = 48'd0;
        end
        if (frame_pos < 3'd6) begin
          crc_acc     = crc8_shift_in(crc_acc, rx_byte);
          frame_bytes = {frame_bytes[39:0], rx_byte};
          frame_pos   = frame_pos + 3'd1;
        end else begin
          want.hum_raw  = frame_bytes[39:20];
          want.temp_raw = frame_bytes[19:0];
          prod           = 64'(want.hum_raw) * 64'd10000;
          want.hum_centi = prod[33:20];
          prod            = 64'(want.temp_raw) * 64'd20000;
          temp_c          = int'(prod >> 20) - 5000;
          want.temp_centi = temp_c[14:0];
          if (frame_bytes[40 + BUSY_BIT]) begin
            want.status = STATUS_BUSY;
          end else if (crc_acc != rx_byte) begin
            want.status = STATUS_CRC;
          end else if (want.temp_raw > TEMP_RAW_LIMIT) begin
            want.status = STATUS_RANGE;
          end else begin
            want.status = STATUS_OK;
          end
          reading_q.push_back(want);
          frame_pos   = 3'd0;
          crc_acc     = CRC_INIT;
          frame_bytes = 48'd0;
        end
      end
      if (out_valid && !out_stall) begin
        got.status     = status_t'(status_code);
        got.hum_raw    = humidity_counts;
        got.temp_raw   = temperature_counts;
        got.hum_centi  = humidity_centi;
        got.temp_centi = temperature_centi;
        if (reading_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result transfer with nothing expected:", $realtime);
            $display("%0t:          got st=%0d hr=%h tr=%h hc=%0d tc=%0d",
                     $realtime, status_code, humidity_counts, temperature_counts,
                     humidity_centi, temperature_centi);
          end
        end else begin
          want = reading_q.pop_front();
          if (got.status !== want.status || got.hum_raw !== want.hum_raw ||
              got.temp_raw !== want.temp_raw || got.hum_centi !== want.hum_centi ||
              got.temp_centi !== want.temp_centi) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch exp st=%0d hr=%h tr=%h hc=%0d tc=%0d",
                       $realtime, want.status, want.hum_raw, want.temp_raw,
                       want.hum_centi, want.temp_centi);
              $display("%0t:          got st=%0d hr=%h tr=%h hc=%0d tc=%0d",
                       $realtime, status_code, humidity_counts, temperature_counts,
                       humidity_centi, temperature_centi);
            end
          end
        end
      end
    end
    pending = reading_q.size();
  end

endmodule

// File: tb/sv/tb_humidity_temp_frame_decoder_unit.sv
// Top of the frame decoder testbench: clock, reset, byte and stall stimulus, verdict.
// Depends on htfd_pkg, humidity_temp_frame_decoder_unit and
// humidity_temp_frame_decoder_checker.
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder_unit import htfd_pkg::*;;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte     = 8'd0;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [1:0]         status_code;
  logic [19:0]        humidity_counts;
  logic [19:0]        temperature_counts;
  logic [13:0]        humidity_centi;
  logic signed [14:0] temperature_centi;

  int fail_count;
  int pending;
  int idle_pct   = 18;
  int stall_pct  = 18;
  int bytes_sent = 0;
  bit hold_req   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  humidity_temp_frame_decoder_unit dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .rx_byte            (rx_byte),
    .frame_start        (frame_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status_code        (status_code),
    .humidity_counts    (humidity_counts),
    .temperature_counts (temperature_counts),
    .humidity_centi     (humidity_centi),
    .temperature_centi  (temperature_centi)
  );

  humidity_temp_frame_decoder_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .rx_byte            (rx_byte),
    .frame_start        (frame_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status_code        (status_code),
    .humidity_counts    (humidity_counts),
    .temperature_counts (temperature_counts),
    .humidity_centi     (humidity_centi),
    .temperature_centi  (temperature_centi),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  function automatic logic [7:0] frame_crc(input logic [47:0] body);
    logic [7:0] crc;
    logic       fb;
    crc = CRC_INIT;
    for (int i = 47; i >= 0; i--) begin
      fb  = crc[7] ^ body[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'd0);
    end
    return crc;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] status_b, input logic [19:0] hum,
                            input logic [19:0] temp, input bit with_start,
                            input bit bad_crc, input int n_bytes);
    logic [47:0] body;
    logic [7:0]  check;
    body  = {status_b, hum, temp};
    check = frame_crc(body);
    if (bad_crc) begin
      check = check ^ 8'($urandom_range(1, 255));
    end
    for (int k = 0; k < n_bytes; k++) begin
      if (k < 6) begin
        send_byte(body[47 - 8 * k -: 8], with_start && (k == 0));
      end else begin
        send_byte(check, 1'b0);
      end
    end
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // receiver: random stall, or a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_humidity_temp_frame_decoder_unit: FAIL");
    $finish;
  end

  initial begin
    logic [7:0]  sb;
    logic [19:0] hum;
    logic [19:0] temp;
    bit          need_start;
    bit          pressed;
    bit          paused;
    int          kind;
    int          pick;
    int          n;
    need_start = 1'b0;
    pressed    = 1'b0;
    paused     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_frame(8'h1C, 20'h00000, 20'h00000, 1'b1, 1'b0, 7);
    send_frame(8'hFF, 20'hFFFFF, 20'hFFFFF, 1'b0, 1'b0, 7);
    send_frame(8'h18, 20'h5A5A5, 20'h12345, 1'b1, 1'b0, 1);
    send_frame(8'h18, 20'h80000, TEMP_RAW_LIMIT, 1'b1, 1'b1, 7);
    drop_valid();
    wait (pending == 0);

    need_start = 1'b1;
    while (bytes_sent < 1000) begin
      if (bytes_sent >= 300 && bytes_sent < 450) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 18;
        stall_pct = 18;
      end
      if (!pressed && bytes_sent >= 600) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && bytes_sent >= 800) begin
        paused = 1'b1;
        drop_valid();
        wait (pending == 0);
      end

      sb    = 8'($urandom);
      sb[7] = ($urandom_range(0, 3) == 0);
      hum   = 20'($urandom);
      pick  = $urandom_range(0, 99);
      if (pick < 60) begin
        temp = 20'($urandom);
      end else if (pick < 80) begin
        temp = 20'($urandom_range(TEMP_RAW_LIMIT - 2, TEMP_RAW_LIMIT + 2));
      end else if (pick < 90) begin
        temp = ($urandom_range(0, 1) == 1) ? 20'hFFFFF : 20'h00000;
      end else begin
        temp = 20'($urandom_range(TEMP_RAW_LIMIT + 1, 20'hFFFFF));
      end

      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_frame(sb, hum, temp, need_start || ($urandom_range(0, 4) != 0), 1'b0, 7);
        need_start = 1'b0;
      end else if (kind < 80) begin
        send_frame(sb, hum, temp, need_start || ($urandom_range(0, 4) != 0), 1'b1, 7);
        need_start = 1'b0;
      end else if (kind < 90) begin
        send_frame(sb, hum, temp, 1'b1, 1'b0, $urandom_range(1, 6));
        need_start = 1'b1;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
        need_start = 1'b1;
      end
    end
    drop_valid();

    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_humidity_temp_frame_decoder_unit: PASS");
    end else begin
      $display("tb_humidity_temp_frame_decoder_unit: FAIL");
    end
    $finish;
  end

endmodule
